[hw/rtl/cnts_pkg.sv]
package cnts_pkg;

    // ring size and derived index widths
    localparam int RING_POINTS = 8;
    localparam int IDX_W       = $clog2(RING_POINTS);
    localparam int CNT_W       = $clog2(RING_POINTS + 1);

    // field widths
    localparam int COORD_W     = 10;
    localparam int WIDTH_W     = 11;
    localparam int MINCNT_W    = 4;
    localparam int OUT_IDX_W   = 3;
    localparam int OUT_SUM_W   = 20;
    localparam int CMP_W       = (CNT_W > MINCNT_W) ? CNT_W : MINCNT_W;

    // distance arithmetic, 8 fraction bits on the root
    localparam int SQ_W        = 2 * COORD_W + 1;
    localparam int FRAC_SHIFT  = 16;
    localparam int ROOT_W      = (SQ_W + FRAC_SHIFT + 1) / 2;
    localparam int RAD_W       = 2 * ROOT_W;
    localparam int REM_W       = ROOT_W + 2;
    localparam int DIST_W      = 20;
    localparam int SUM_W       = DIST_W + 1;
    localparam int LIM_SQ_W    = 2 * WIDTH_W;

    localparam logic [SUM_W-1:0] SUM_MAX = '1;

    // queue between front and walk
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    // configuration register map
    localparam int CFG_ADDR_W  = 4;
    localparam int CFG_IDX_W   = 2;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_WIDTH = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_WIDTH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_COUNT = 2'd2;

    // stream widths
    localparam int S_DATA_W    = 24;
    localparam int M_DATA_W    = 24;

    typedef struct packed {
        logic [COORD_W-1:0] y;
        logic [COORD_W-1:0] x;
    } point_t;

    typedef point_t [RING_POINTS-1:0] ring_t;

    typedef struct packed {
        ring_t            pts;
        logic [CNT_W-1:0] count;
    } job_t;

    typedef struct packed {
        logic valid;
        job_t job;
    } push_t;

    typedef struct packed {
        logic                 found;
        logic [OUT_IDX_W-1:0] index;
        logic [OUT_SUM_W-1:0] sum;
    } result_t;

endpackage

[hw/rtl/cnts_front.sv]
module cnts_front (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  cnts_pkg::point_t              in_point,
    input  logic                          in_last,
    input  logic                          q_full,
    output cnts_pkg::push_t               q_push
);
    import cnts_pkg::*;

    ring_t            ring_reg;
    ring_t            ring_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic [CNT_W-1:0] count_inc;
    logic             room;
    logic             accept;

    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready;
    assign room     = count_reg < CNT_W'(RING_POINTS);
    assign count_inc = room ? count_reg + CNT_W'(1) : count_reg;

    // store the point unless the ring is full
    always_comb begin
        ring_next = ring_reg;
        if (room) begin
            ring_next[count_reg[IDX_W-1:0]] = in_point;
        end
    end

    // count restarts once the ring is closed
    always_comb begin
        count_next = count_reg;
        if (accept) begin
            count_next = in_last ? '0 : count_inc;
        end
    end

    // closed ring goes to the queue as one job
    always_comb begin
        q_push.valid     = accept && in_last;
        q_push.job.pts   = ring_next;
        q_push.job.count = count_inc;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            ring_reg <= ring_next;
        end
    end

endmodule

[hw/rtl/cnts_queue.sv]
module cnts_queue (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  cnts_pkg::push_t      push,
    output logic                 full,
    input  logic                 pop,
    output logic                 not_empty,
    output cnts_pkg::job_t       pop_job
);
    import cnts_pkg::*;

    job_t              slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_next;
    logic [QPTR_W:0]   fill_reg;
    logic [QPTR_W:0]   fill_next;
    logic              do_push;
    logic              do_pop;

    assign full      = fill_reg == (QPTR_W + 1)'(QUEUE_DEPTH);
    assign not_empty = fill_reg != '0;
    assign do_push   = push.valid && !full;
    assign do_pop    = pop && not_empty;
    assign pop_job   = slot_reg[rd_ptr_reg];

    // pointer and fill bookkeeping
    always_comb begin
        wr_ptr_next = do_push ? wr_ptr_reg + QPTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + QPTR_W'(1) : rd_ptr_reg;
        fill_next   = fill_reg;
        if (do_push && !do_pop) begin
            fill_next = fill_reg + (QPTR_W + 1)'(1);
        end else if (do_pop && !do_push) begin
            fill_next = fill_reg - (QPTR_W + 1)'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            slot_reg[wr_ptr_reg] <= push.job;
        end
    end

endmodule

[hw/rtl/cnts_sqrt.sv]
module cnts_sqrt (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         start,
    input  logic [cnts_pkg::SQ_W-1:0]    square,
    output logic                         done,
    output logic [cnts_pkg::ROOT_W-1:0]  root
);
    import cnts_pkg::*;

    localparam int ITER_W = $clog2(ROOT_W);

    logic              busy_reg;
    logic              done_reg;
    logic [ITER_W-1:0] cnt_reg;
    logic [RAD_W-1:0]  rad_reg;
    logic [REM_W-1:0]  rem_reg;
    logic [ROOT_W-1:0] root_reg;
    logic [REM_W+1:0]  rem_shift;
    logic [REM_W+1:0]  trial;
    logic              take;
    logic [REM_W-1:0]  rem_next;
    logic [ROOT_W-1:0] root_next;

    // one root bit per cycle, restoring digit recurrence
    always_comb begin
        rem_shift = {rem_reg, rad_reg[RAD_W-1 -: 2]};
        trial     = {{(REM_W - ROOT_W){1'b0}}, root_reg, 2'b01};
        take      = rem_shift >= trial;
        rem_next  = take ? REM_W'(rem_shift - trial) : REM_W'(rem_shift);
        root_next = {root_reg[ROOT_W-2:0], take};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + ITER_W'(1);
                if (cnt_reg == ITER_W'(ROOT_W - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rad_reg  <= RAD_W'({square, {FRAC_SHIFT{1'b0}}});
            rem_reg  <= '0;
            root_reg <= '0;
        end else if (busy_reg) begin
            rad_reg  <= {rad_reg[RAD_W-3:0], 2'b00};
            rem_reg  <= rem_next;
            root_reg <= root_next;
        end
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule

[hw/rtl/cnts_walk.sv]
module cnts_walk (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic [cnts_pkg::WIDTH_W-1:0]    min_width,
    input  logic [cnts_pkg::WIDTH_W-1:0]    max_width,
    input  logic [cnts_pkg::MINCNT_W-1:0]   min_count,
    input  logic                            q_not_empty,
    input  cnts_pkg::job_t                  q_job,
    output logic                            q_pop,
    output logic                            res_valid,
    input  logic                            res_ready,
    output cnts_pkg::result_t               res
);
    import cnts_pkg::*;

    typedef enum logic [9:0] {
        ST_IDLE = 10'b00_0000_0001,
        ST_STEP = 10'b00_0000_0010,
        ST_RD_A = 10'b00_0000_0100,
        ST_RD_B = 10'b00_0000_1000,
        ST_SQR  = 10'b00_0001_0000,
        ST_SUM  = 10'b00_0010_0000,
        ST_TEST = 10'b00_0100_0000,
        ST_ROOT = 10'b00_1000_0000,
        ST_CMP  = 10'b01_0000_0000,
        ST_DONE = 10'b10_0000_0000
    } walk_state_t;

    walk_state_t         state_reg;
    walk_state_t         state_next;
    ring_t               ring_reg;
    logic [CNT_W-1:0]    n_reg;
    logic [CNT_W-1:0]    i_reg;
    logic [IDX_W-1:0]    mid_reg;
    logic                phase_reg;
    point_t              a_reg;
    point_t              b_reg;
    logic [2*COORD_W-1:0] dxsq_reg;
    logic [2*COORD_W-1:0] dysq_reg;
    logic [SQ_W-1:0]     sq_reg;
    logic [LIM_SQ_W-1:0] lo_sq_reg;
    logic [LIM_SQ_W-1:0] hi_sq_reg;
    logic [DIST_W-1:0]   prev_reg;
    logic [DIST_W-1:0]   d0_reg;
    logic [DIST_W-1:0]   d1_reg;
    logic [SUM_W-1:0]    best_reg;
    logic [IDX_W-1:0]    chosen_reg;
    logic                found_reg;
    logic                res_valid_reg;
    result_t             res_reg;

    logic [IDX_W-1:0]    b_idx;
    logic [CNT_W:0]      wrap;
    logic [IDX_W-1:0]    rd_idx;
    point_t              rd_point;
    logic [COORD_W-1:0]  dx;
    logic [COORD_W-1:0]  dy;
    logic                in_window;
    logic                count_ok;
    logic [SUM_W-1:0]    sum;
    logic                sqrt_start;
    logic                sqrt_done;
    logic [ROOT_W-1:0]   sqrt_root;
    logic                out_free;

    // neighbour index: i-1 first, then (i+1) mod n
    always_comb begin
        wrap = (CNT_W + 1)'(i_reg) + (CNT_W + 1)'(1);
        if (wrap >= (CNT_W + 1)'(n_reg)) begin
            wrap = wrap - (CNT_W + 1)'(n_reg);
        end
        if (wrap >= (CNT_W + 1)'(n_reg)) begin
            wrap = wrap - (CNT_W + 1)'(n_reg);
        end
        b_idx = phase_reg ? IDX_W'(wrap) : IDX_W'(i_reg - CNT_W'(1));
    end

    // single read port on the ring copy
    assign rd_idx   = (state_reg == ST_RD_A) ? mid_reg : b_idx;
    assign rd_point = ring_reg[rd_idx];

    assign dx = (a_reg.x > b_reg.x) ? a_reg.x - b_reg.x : b_reg.x - a_reg.x;
    assign dy = (a_reg.y > b_reg.y) ? a_reg.y - b_reg.y : b_reg.y - a_reg.y;

    assign in_window = (LIM_SQ_W'(sq_reg) >= lo_sq_reg) && (LIM_SQ_W'(sq_reg) <= hi_sq_reg);
    assign count_ok  = (CMP_W'(q_job.count) >= CMP_W'(min_count)) && (q_job.count != '0);
    assign sum       = SUM_W'(d0_reg) + SUM_W'(d1_reg);
    assign out_free  = !res_valid_reg || res_ready;

    assign sqrt_start = (state_reg == ST_TEST) && in_window;
    assign q_pop      = (state_reg == ST_IDLE) && q_not_empty;

    cnts_sqrt u_sqrt (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (sqrt_start),
        .square  (sq_reg),
        .done    (sqrt_done),
        .root    (sqrt_root)
    );

    // walk sequencer
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (q_not_empty) begin
                    state_next = count_ok ? ST_STEP : ST_DONE;
                end
            end
            ST_STEP: state_next = (i_reg == '0) ? ST_DONE : ST_RD_A;
            ST_RD_A: state_next = ST_RD_B;
            ST_RD_B: state_next = ST_SQR;
            ST_SQR:  state_next = ST_SUM;
            ST_SUM:  state_next = ST_TEST;
            ST_TEST: state_next = in_window ? ST_ROOT : ST_STEP;
            ST_ROOT: begin
                if (sqrt_done) begin
                    if (phase_reg || prev_reg != '0) begin
                        state_next = ST_CMP;
                    end else begin
                        state_next = ST_RD_B;
                    end
                end
            end
            ST_CMP:  state_next = ST_STEP;
            ST_DONE: state_next = out_free ? ST_IDLE : ST_DONE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            res_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (state_reg == ST_DONE && out_free) begin
                res_valid_reg <= 1'b1;
            end else if (res_ready) begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        case (state_reg)
            ST_IDLE: begin
                ring_reg   <= q_job.pts;
                n_reg      <= q_job.count;
                i_reg      <= q_job.count;
                lo_sq_reg  <= LIM_SQ_W'(min_width) * LIM_SQ_W'(min_width);
                hi_sq_reg  <= LIM_SQ_W'(max_width) * LIM_SQ_W'(max_width);
                prev_reg   <= '0;
                best_reg   <= SUM_MAX;
                chosen_reg <= '0;
                found_reg  <= 1'b0;
            end
            ST_STEP: begin
                mid_reg   <= (i_reg == n_reg) ? '0 : IDX_W'(i_reg);
                phase_reg <= 1'b0;
            end
            ST_RD_A: a_reg <= rd_point;
            ST_RD_B: b_reg <= rd_point;
            ST_SQR: begin
                dxsq_reg <= (2 * COORD_W)'(dx) * (2 * COORD_W)'(dx);
                dysq_reg <= (2 * COORD_W)'(dy) * (2 * COORD_W)'(dy);
            end
            ST_SUM:  sq_reg <= SQ_W'(dxsq_reg) + SQ_W'(dysq_reg);
            ST_TEST: begin
                if (!in_window) begin
                    if (!phase_reg) begin
                        // first distance fails: skip the next index too
                        prev_reg <= '0;
                        i_reg    <= (i_reg >= CNT_W'(2)) ? i_reg - CNT_W'(2) : '0;
                    end else begin
                        i_reg <= i_reg - CNT_W'(1);
                    end
                end
            end
            ST_ROOT: begin
                if (sqrt_done) begin
                    if (!phase_reg) begin
                        d0_reg   <= DIST_W'(sqrt_root);
                        prev_reg <= DIST_W'(sqrt_root);
                        // reuse the last distance that passed the window
                        d1_reg    <= prev_reg;
                        phase_reg <= 1'b1;
                    end else begin
                        d1_reg <= DIST_W'(sqrt_root);
                    end
                end
            end
            ST_CMP: begin
                if (sum < best_reg) begin
                    best_reg   <= sum;
                    chosen_reg <= mid_reg;
                    found_reg  <= 1'b1;
                end
                i_reg <= i_reg - CNT_W'(1);
            end
            ST_DONE: begin
                if (out_free) begin
                    res_reg.found <= found_reg;
                    res_reg.index <= found_reg ? OUT_IDX_W'(chosen_reg) : '0;
                    res_reg.sum   <= found_reg ? best_reg[OUT_SUM_W-1:0] : '0;
                end
            end
            default: begin
            end
        endcase
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

endmodule

[hw/rtl/closest_neighbour_triple_select_core.sv]
// channel   | ports                 | contents
// ----------+-----------------------+-------------------------------------------
// input     | s_tvalid/s_tready     | one ring point per item, tlast closes ring
// result    | m_tvalid/m_tready     | one item per closed ring
// config    | apb (psel..prdata)    | min_width @0x0, max_width @0x4, min_count @0x8
//
// points are taken one per cycle while the queue has room; a closed ring goes to a
// two-entry job queue. per distance the walk reads both points, squares, sums and
// tests the window, and if inside takes the root in one root unit shared by every
// step; each ring ends in a handoff and a result.
// reset is synchronous and clears counters, queue and sequencer; no clearing pass.
// input stalls only when the job queue is full; a waiting result holds the walk.
module closest_neighbour_triple_select_core (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    // point_x [9:0], point_y [19:10], zero [23:20]
    input  logic [cnts_pkg::S_DATA_W-1:0]         s_tdata,
    input  logic                                  s_tlast,
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    // best_index [2:0], best_sum [22:3], zero [23]
    output logic [cnts_pkg::M_DATA_W-1:0]         m_tdata,
    // found [0]
    output logic [0:0]                            m_tuser,
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic [cnts_pkg::CFG_ADDR_W-1:0]       paddr,
    input  logic [31:0]                           pwdata,
    output logic [31:0]                           prdata,
    output logic                                  pready
);
    import cnts_pkg::*;

    logic [WIDTH_W-1:0]   min_width_reg;
    logic [WIDTH_W-1:0]   max_width_reg;
    logic [MINCNT_W-1:0]  min_count_reg;
    logic [CFG_IDX_W-1:0] cfg_idx;
    logic                 cfg_write;
    point_t               in_point;
    push_t                q_push;
    logic                 q_full;
    logic                 q_pop;
    logic                 q_not_empty;
    job_t                 q_job;
    result_t              res;

    // configuration port
    assign pready    = 1'b1;
    assign cfg_idx   = paddr[CFG_ADDR_W-1:2];
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            min_width_reg <= WIDTH_W'(25);
            max_width_reg <= WIDTH_W'(70);
            min_count_reg <= MINCNT_W'(4);
        end else if (cfg_write) begin
            case (cfg_idx)
                REG_MIN_WIDTH: min_width_reg <= pwdata[WIDTH_W-1:0];
                REG_MAX_WIDTH: max_width_reg <= pwdata[WIDTH_W-1:0];
                REG_MIN_COUNT: min_count_reg <= pwdata[MINCNT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (cfg_idx)
            REG_MIN_WIDTH: prdata = 32'(min_width_reg);
            REG_MAX_WIDTH: prdata = 32'(max_width_reg);
            REG_MIN_COUNT: prdata = 32'(min_count_reg);
            default:       prdata = '0;
        endcase
    end

    // unpack the input item
    assign in_point.x = s_tdata[COORD_W-1:0];
    assign in_point.y = s_tdata[2*COORD_W-1:COORD_W];

    cnts_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .in_point (in_point),
        .in_last  (s_tlast),
        .q_full   (q_full),
        .q_push   (q_push)
    );

    cnts_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .pop_job   (q_job)
    );

    cnts_walk u_walk (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .min_width   (min_width_reg),
        .max_width   (max_width_reg),
        .min_count   (min_count_reg),
        .q_not_empty (q_not_empty),
        .q_job       (q_job),
        .q_pop       (q_pop),
        .res_valid   (m_tvalid),
        .res_ready   (m_tready),
        .res         (res)
    );

    // pack the result item
    assign m_tdata = M_DATA_W'({res.sum, res.index});
    assign m_tuser = res.found;

    // a not-found result carries zero index and sum
    a_notfound_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser[0] |-> m_tdata == '0)
        else $error("not-found result with nonzero payload");

    // a closed ring is never offered to a full queue
    a_no_push_full: assert property (@(posedge aclk) disable iff (!aresetn)
        q_push.valid |-> !q_full)
        else $error("job pushed into a full queue");

    // reset empties the result register
    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

endmodule

[sim/closest_neighbour_triple_select_core_tb.sv]
`timescale 1ns / 1ps

module closest_neighbour_triple_select_core_tb;

    localparam int CYCLE_LIMIT = 600000;
    localparam int WALK_SETTLE = 600;
    localparam int HOLD_CYCLES = 3000;
    localparam int COORD_MAX   = (1 << cnts_pkg::COORD_W) - 1;

    typedef enum int {SINK_OPEN, SINK_HALF, SINK_SPARSE, SINK_LIGHT} sink_mode_t;

    typedef logic [cnts_pkg::COORD_W-1:0] coord_t;

    logic                                  aclk     = 1'b0;
    logic                                  aresetn  = 1'b0;
    logic [cnts_pkg::S_DATA_W-1:0]         s_tdata  = '0;
    logic                                  s_tlast  = 1'b0;
    logic                                  s_tvalid = 1'b0;
    logic                                  s_tready;
    logic [cnts_pkg::M_DATA_W-1:0]         m_tdata;
    logic [0:0]                            m_tuser;
    logic                                  m_tvalid;
    logic                                  m_tready = 1'b0;
    logic                                  psel     = 1'b0;
    logic                                  penable  = 1'b0;
    logic                                  pwrite   = 1'b0;
    logic [cnts_pkg::CFG_ADDR_W-1:0]       paddr    = '0;
    logic [31:0]                           pwdata   = '0;
    logic [31:0]                           prdata;
    logic                                  pready;

    // predictor copy of the ring and the window registers
    coord_t                         ring_px [cnts_pkg::RING_POINTS];
    coord_t                         ring_py [cnts_pkg::RING_POINTS];
    int                             ring_fill       = 0;
    logic [cnts_pkg::WIDTH_W-1:0]   cfg_min_width   = 11'd25;
    logic [cnts_pkg::WIDTH_W-1:0]   cfg_max_width   = 11'd70;
    logic [cnts_pkg::MINCNT_W-1:0]  cfg_min_count   = 4'd4;

    cnts_pkg::result_t              expected_triples[$];
    int                             mismatch_count  = 0;
    int                             cycle_count     = 0;
    int                             burst_left      = 0;
    bit                             gaps_on         = 1'b1;
    int                             sink_hold       = 0;

    closest_neighbour_triple_select_core i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // clock
    initial begin
        forever #10 aclk = ~aclk;
    end

    // run limit
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    // squared pixel distance between two stored points
    function automatic longint unsigned sq_between(int a, int b);
        longint dx;
        longint dy;
        dx = longint'(ring_px[a]) - longint'(ring_px[b]);
        dy = longint'(ring_py[a]) - longint'(ring_py[b]);
        return unsigned'(dx * dx + dy * dy);
    endfunction

    function automatic bit in_window(longint unsigned sq);
        longint unsigned lo;
        longint unsigned hi;
        lo = 64'(cfg_min_width) * 64'(cfg_min_width);
        hi = 64'(cfg_max_width) * 64'(cfg_max_width);
        return (sq >= lo) && (sq <= hi);
    endfunction

    // floor of the root of sq, 8 fraction bits
    function automatic logic [cnts_pkg::DIST_W-1:0] fixed_root(longint unsigned sq);
        longint unsigned v;
        longint unsigned rt;
        longint unsigned b;
        v  = sq << 16;
        rt = 0;
        b  = 64'd1 << 62;
        while (b > v)
            b >>= 2;
        while (b != 0) begin
            if (v >= rt + b) begin
                v  = v - (rt + b);
                rt = (rt >> 1) + b;
            end else begin
                rt = rt >> 1;
            end
            b >>= 2;
        end
        return rt[cnts_pkg::DIST_W-1:0];
    endfunction

    // walk the closed ring from the top index down, keep the smallest sum
    function automatic cnts_pkg::result_t closest_triple();
        int                              n;
        int                              i;
        int                              mid;
        longint unsigned                 sq0;
        longint unsigned                 sq1;
        logic [cnts_pkg::DIST_W-1:0]     d0;
        logic [cnts_pkg::DIST_W-1:0]     d1;
        logic [cnts_pkg::DIST_W-1:0]     prev_d;
        logic [cnts_pkg::DIST_W-1:0]     old_d;
        logic [cnts_pkg::SUM_W-1:0]      best;
        logic [cnts_pkg::SUM_W-1:0]      total;
        logic [cnts_pkg::OUT_IDX_W-1:0]  best_idx;
        bit                              skip;
        cnts_pkg::result_t               r;
        n        = ring_fill;
        prev_d   = '0;
        best     = cnts_pkg::SUM_MAX;
        best_idx = '0;
        r        = '0;
        if (n >= int'(cfg_min_count) && n >= 1) begin
            i = n;
            while (i > 0) begin
                mid   = i % n;
                sq0   = sq_between(mid, i - 1);
                old_d = prev_d;
                if (!in_window(sq0)) begin
                    // first side out of window: drop it and skip the neighbour too
                    prev_d = '0;
                    i = (i >= 2) ? i - 2 : 0;
                end else begin
                    d0     = fixed_root(sq0);
                    prev_d = d0;
                    skip   = 1'b0;
                    d1     = '0;
                    if (old_d != 0) begin
                        d1 = old_d;
                    end else begin
                        sq1 = sq_between(mid, (i + 1) % n);
                        if (!in_window(sq1))
                            skip = 1'b1;
                        else
                            d1 = fixed_root(sq1);
                    end
                    if (!skip) begin
                        total = {1'b0, d0} + {1'b0, d1};
                        if (total < best) begin
                            best     = total;
                            best_idx = mid[cnts_pkg::OUT_IDX_W-1:0];
                            r.found  = 1'b1;
                        end
                    end
                    i = i - 1;
                end
            end
        end
        if (r.found) begin
            r.index = best_idx;
            r.sum   = best[cnts_pkg::OUT_SUM_W-1:0];
        end
        return r;
    endfunction

    // store an accepted point, close the ring on the flag
    task automatic record_point(input coord_t x, input coord_t y, input bit close_ring);
        if (ring_fill < cnts_pkg::RING_POINTS) begin
            ring_px[ring_fill] = x;
            ring_py[ring_fill] = y;
            ring_fill++;
        end
        if (close_ring) begin
            expected_triples = {expected_triples, closest_triple()};
            ring_fill = 0;
        end
    endtask

    // offer one point, bursts with random gaps
    task automatic send_point(input coord_t x, input coord_t y, input bit close_ring);
        int gap;
        if (gaps_on && burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        if (burst_left > 0)
            burst_left--;
        s_tdata  <= {{(cnts_pkg::S_DATA_W - 2 * cnts_pkg::COORD_W){1'b0}}, y, x};
        s_tlast  <= close_ring;
        s_tvalid <= 1'b1;
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        record_point(x, y, close_ring);
    endtask

    // ring as a random walk whose steps mostly land near the window
    task automatic send_walk_ring(input int size);
        int x;
        int y;
        int span;
        int dx;
        int dy;
        int k;
        x    = $urandom_range(0, COORD_MAX);
        y    = $urandom_range(0, COORD_MAX);
        span = (cfg_max_width > 700) ? 525 : (int'(cfg_max_width) * 3) / 4;
        for (k = 0; k < size; k++) begin
            send_point(x[cnts_pkg::COORD_W-1:0], y[cnts_pkg::COORD_W-1:0], k == size - 1);
            dx = $urandom_range(0, span);
            dy = $urandom_range(0, span);
            if ($urandom_range(0, 1) == 1)
                dx = -dx;
            if ($urandom_range(0, 1) == 1)
                dy = -dy;
            x = (x + dx < 0 || x + dx > COORD_MAX) ? x - dx : x + dx;
            y = (y + dy < 0 || y + dy > COORD_MAX) ? y - dy : y + dy;
            x = (x < 0) ? 0 : ((x > COORD_MAX) ? COORD_MAX : x);
            y = (y < 0) ? 0 : ((y > COORD_MAX) ? COORD_MAX : y);
        end
    endtask

    // ring of unrelated points
    task automatic send_noise_ring(input int size);
        int k;
        for (k = 0; k < size; k++)
            send_point(coord_t'($urandom_range(0, COORD_MAX)),
                       coord_t'($urandom_range(0, COORD_MAX)), k == size - 1);
    endtask

    // stop offering, wait for every pending triple, let the walk settle
    task automatic drain();
        s_tvalid <= 1'b0;
        while (expected_triples.size() != 0)
            @(posedge aclk);
        repeat (WALK_SETTLE) @(posedge aclk);
    endtask

    task automatic apb_write(input logic [cnts_pkg::CFG_IDX_W-1:0] idx, input int value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= 32'(value);
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready)
            @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // new window and count, only once the block is idle
    task automatic write_window(input int min_w, input int max_w, input int min_c);
        drain();
        apb_write(cnts_pkg::REG_MIN_WIDTH, min_w);
        cfg_min_width = min_w[cnts_pkg::WIDTH_W-1:0];
        apb_write(cnts_pkg::REG_MAX_WIDTH, max_w);
        cfg_max_width = max_w[cnts_pkg::WIDTH_W-1:0];
        apb_write(cnts_pkg::REG_MIN_COUNT, min_c);
        cfg_min_count = min_c[cnts_pkg::MINCNT_W-1:0];
    endtask

    task automatic test_directed_cases();
        // reset window: square of side 50, every sum ties so index 0, visited first, wins
        send_point(10'd100, 10'd100, 1'b0);
        send_point(10'd150, 10'd100, 1'b0);
        send_point(10'd150, 10'd150, 1'b0);
        send_point(10'd100, 10'd150, 1'b1);
        // three points, below the reset count
        send_point(10'd200, 10'd200, 1'b0);
        send_point(10'd230, 10'd200, 1'b0);
        send_point(10'd230, 10'd230, 1'b1);
        write_window(0, 2047, 1);
        // single point ring closes on itself
        send_point(10'd1023, 10'd1023, 1'b1);
        // corners of the coordinate range
        send_point(10'd0, 10'd0, 1'b0);
        send_point(10'd1023, 10'd0, 1'b0);
        send_point(10'd1023, 10'd1023, 1'b0);
        send_point(10'd0, 10'd1023, 1'b1);
        // overflow: the last two points are dropped, the flag still closes
        send_walk_ring(10);
        // empty window
        write_window(100, 50, 2);
        send_point(10'd0, 10'd0, 1'b0);
        send_point(10'd60, 10'd0, 1'b0);
        send_point(10'd60, 10'd60, 1'b1);
        drain();
    endtask

    task automatic test_random_rings();
        int phase;
        int sent;
        int size;
        int pick;
        int min_w;
        for (phase = 0; phase < 8; phase++) begin
            case (phase)
                0: write_window(25, 70, 4);
                1: write_window(0, 2047, 1);
                2: write_window(2047, 2047, 8);
                3: write_window(0, 0, 2);
                4: write_window(0, 2047, 8);
                default: begin
                    min_w = $urandom_range(0, 60);
                    write_window(min_w, min_w + $urandom_range(0, 150), $urandom_range(1, 8));
                end
            endcase
            gaps_on = (phase % 3 != 2);
            sent = 0;
            while (sent < 100) begin
                pick = $urandom_range(0, 9);
                if (pick < 7) begin
                    size = ($urandom_range(0, 7) == 0) ? 1 : $urandom_range(2, 8);
                    send_walk_ring(size);
                end else if (pick < 9) begin
                    size = $urandom_range(1, 8);
                    send_noise_ring(size);
                end else begin
                    size = $urandom_range(9, 12);
                    send_walk_ring(size);
                end
                sent += size;
            end
        end
        gaps_on = 1'b1;
        drain();
    endtask

    // receiver holds off while points keep coming, input must stall
    task automatic test_backpressure_fill();
        int r;
        write_window(0, 2047, 1);
        gaps_on   = 1'b0;
        sink_hold = HOLD_CYCLES;
        for (r = 0; r < 12; r++)
            send_walk_ring(4);
        gaps_on = 1'b1;
        drain();
    endtask

    // sender stops until every triple is back, then resumes
    task automatic test_pause_until_empty();
        int round;
        int r;
        write_window(20, 90, 3);
        for (round = 0; round < 3; round++) begin
            for (r = 0; r < 3; r++)
                send_walk_ring(5);
            drain();
        end
    endtask

    // receiver stall patterns, long hold on request
    initial begin : result_sink
        sink_mode_t mode;
        int         span_left;
        mode      = SINK_OPEN;
        span_left = 0;
        forever begin
            @(posedge aclk);
            if (sink_hold > 0) begin
                sink_hold--;
                m_tready <= 1'b0;
            end else begin
                if (span_left == 0) begin
                    mode      = sink_mode_t'($urandom_range(0, 3));
                    span_left = $urandom_range(10, 150);
                end
                span_left--;
                case (mode)
                    SINK_OPEN:   m_tready <= 1'b1;
                    SINK_HALF:   m_tready <= ($urandom_range(0, 1) == 1);
                    SINK_SPARSE: m_tready <= ($urandom_range(0, 3) == 0);
                    default:     m_tready <= ($urandom_range(0, 7) != 0);
                endcase
            end
        end
    end

    // compare each accepted item with the oldest pending triple
    always @(posedge aclk) begin : result_check
        cnts_pkg::result_t got;
        cnts_pkg::result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got.found = m_tuser[0];
            got.index = m_tdata[cnts_pkg::OUT_IDX_W-1:0];
            got.sum   = m_tdata[cnts_pkg::OUT_IDX_W +: cnts_pkg::OUT_SUM_W];
            if (expected_triples.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected item: found=%0d index=%0d sum=%0d",
                             got.found, got.index, got.sum);
            end else begin
                want = expected_triples.pop_front();
                if (got.found !== want.found || got.index !== want.index ||
                    got.sum !== want.sum) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display({"mismatch: expected found=%0d index=%0d sum=%0d, ",
                                  "got found=%0d index=%0d sum=%0d"},
                                 want.found, want.index, want.sum,
                                 got.found, got.index, got.sum);
                end
            end
        end
    end

    initial begin
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed_cases();
        test_random_rings();
        test_backpressure_fill();
        test_pause_until_empty();
        drain();
        if (mismatch_count == 0 && expected_triples.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
